[rtl/stq_pkg.sv]
// Package for the sorted timer queue: word types, command and status codes,
// controller states and the controller-to-datapath command and status types.
// No dependencies.
`default_nettype none

package stq_pkg;

  // Command codes carried in the action field
  typedef enum logic [2:0] {
    ACT_ALLOC      = 3'd0,
    ACT_FREE       = 3'd1,
    ACT_BIND       = 3'd2,
    ACT_ARM        = 3'd3,
    ACT_CANCEL     = 3'd4,
    ACT_CANCEL_ALL = 3'd5
  } act_e;

  // Result status codes
  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NO_FREE = 2'd1,
    STS_BAD     = 2'd2,
    STS_RUNNING = 2'd3
  } sts_e;

  // Per-entry state
  typedef enum logic [1:0] {
    ES_FREE  = 2'd0,
    ES_ALLOC = 2'd1,
    ES_RUN   = 2'd2
  } ent_st_e;

  localparam logic [31:0] DL_ALL_ONES = 32'hffffffff;
  localparam logic [3:0]  CNT_MAX     = 4'hf;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  timer_index;
    logic [31:0] delay;
    logic [31:0] now;
    logic [3:0]  queue_id;
    logic [31:0] message;
    logic        auto_cancel;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  allocated_index;
    logic        was_running;
    logic [3:0]  cancelled_count;
    logic [3:0]  head_index;
    logic [31:0] next_deadline;
  } out_word_t;

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_ALLOC, S_UNL_A, S_UNL_B, S_UNL_HD, S_UNL_WALK, S_UNL_FIN,
    S_INS_A, S_INS_N, S_INS_C, S_INS_W, S_CA_RD, S_CA_CK, S_CA_NEXT, S_DONE
  } ctl_state_e;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_SET_ERR, OP_SET_BUSY, OP_SCAN_START, OP_ALLOC_STEP,
    OP_FREE_IDLE, OP_BIND, OP_ARM_START, OP_CANCEL_START, OP_ENT_START,
    OP_UNL_A, OP_UNL_B, OP_UNL_HD, OP_UNL_WALK, OP_UNL_FIN,
    OP_INS_A, OP_INS_N, OP_INS_C, OP_INS_W,
    OP_CA_RD, OP_CA_CK, OP_CA_NEXT, OP_OUT_LOAD
  } dp_op_e;

  // Datapath status seen by the controller
  typedef struct packed {
    logic [2:0] action;
    logic       idx_ok;
    logic       qid_ok;
    ent_st_e    idx_st;
    ent_st_e    scan_st;
    logic       scan_last;
    logic       ca_match;
    logic       head_is_e;
    logic       ins_front;
    logic       walk_hit;
    logic       walk_end;
    logic       ins_hit;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/stq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/stq_ctrl.sv]
// Command sequencer for the sorted timer queue: steps the datapath through
// allocate, unlink, insert and cancel-all walks. Depends on stq_pkg.
`default_nettype none

module stq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  input  wire stq_pkg::dp_stat_t  stat_i,
  output      stq_pkg::dp_op_e    op_o
);

  stq_pkg::ctl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic load;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath op
  always_comb begin
    state_d = state_q;
    op_o    = stq_pkg::OP_NONE;
    load    = 1'b0;
    case (state_q)
      stq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_o    = stq_pkg::OP_LATCH;
          state_d = stq_pkg::S_DEC;
        end
      end
      stq_pkg::S_DEC: begin
        state_d = stq_pkg::S_DONE;
        case (stat_i.action)
          stq_pkg::ACT_ALLOC: begin
            op_o    = stq_pkg::OP_SCAN_START;
            state_d = stq_pkg::S_ALLOC;
          end
          stq_pkg::ACT_FREE: begin
            if (!stat_i.idx_ok) begin
              op_o = stq_pkg::OP_SET_ERR;
            end else if (stat_i.idx_st == stq_pkg::ES_RUN) begin
              op_o    = stq_pkg::OP_ENT_START;
              state_d = stq_pkg::S_UNL_A;
            end else begin
              op_o = stq_pkg::OP_FREE_IDLE;
            end
          end
          stq_pkg::ACT_BIND: begin
            if (!stat_i.idx_ok || stat_i.idx_st == stq_pkg::ES_FREE || !stat_i.qid_ok) begin
              op_o = stq_pkg::OP_SET_ERR;
            end else begin
              op_o = stq_pkg::OP_BIND;
            end
          end
          stq_pkg::ACT_ARM: begin
            if (!stat_i.idx_ok || stat_i.idx_st == stq_pkg::ES_FREE) begin
              op_o = stq_pkg::OP_SET_ERR;
            end else if (stat_i.idx_st == stq_pkg::ES_RUN) begin
              op_o = stq_pkg::OP_SET_BUSY;
            end else begin
              op_o    = stq_pkg::OP_ARM_START;
              state_d = stq_pkg::S_INS_A;
            end
          end
          stq_pkg::ACT_CANCEL: begin
            if (!stat_i.idx_ok) begin
              op_o = stq_pkg::OP_SET_ERR;
            end else if (stat_i.idx_st == stq_pkg::ES_RUN) begin
              op_o    = stq_pkg::OP_CANCEL_START;
              state_d = stq_pkg::S_UNL_A;
            end
          end
          stq_pkg::ACT_CANCEL_ALL: begin
            op_o    = stq_pkg::OP_SCAN_START;
            state_d = stq_pkg::S_CA_RD;
          end
          default: begin
            op_o = stq_pkg::OP_SET_ERR;
          end
        endcase
      end
      stq_pkg::S_ALLOC: begin
        op_o = stq_pkg::OP_ALLOC_STEP;
        if (stat_i.scan_st == stq_pkg::ES_FREE || stat_i.scan_last) begin
          state_d = stq_pkg::S_DONE;
        end
      end
      stq_pkg::S_UNL_A: begin
        op_o    = stq_pkg::OP_UNL_A;
        state_d = stq_pkg::S_UNL_B;
      end
      stq_pkg::S_UNL_B: begin
        op_o    = stq_pkg::OP_UNL_B;
        state_d = stat_i.head_is_e ? stq_pkg::S_UNL_HD : stq_pkg::S_UNL_WALK;
      end
      stq_pkg::S_UNL_HD: begin
        op_o    = stq_pkg::OP_UNL_HD;
        state_d = stq_pkg::S_UNL_FIN;
      end
      stq_pkg::S_UNL_WALK: begin
        op_o = stq_pkg::OP_UNL_WALK;
        if (stat_i.walk_hit || stat_i.walk_end) begin
          state_d = stq_pkg::S_UNL_FIN;
        end
      end
      stq_pkg::S_UNL_FIN: begin
        op_o    = stq_pkg::OP_UNL_FIN;
        state_d = (stat_i.action == stq_pkg::ACT_CANCEL_ALL) ? stq_pkg::S_CA_NEXT
                                                              : stq_pkg::S_DONE;
      end
      stq_pkg::S_INS_A: begin
        op_o    = stq_pkg::OP_INS_A;
        state_d = stat_i.ins_front ? stq_pkg::S_DONE : stq_pkg::S_INS_N;
      end
      stq_pkg::S_INS_N: begin
        op_o    = stq_pkg::OP_INS_N;
        state_d = stq_pkg::S_INS_C;
      end
      stq_pkg::S_INS_C: begin
        op_o    = stq_pkg::OP_INS_C;
        state_d = stat_i.ins_hit ? stq_pkg::S_INS_W : stq_pkg::S_INS_N;
      end
      stq_pkg::S_INS_W: begin
        op_o    = stq_pkg::OP_INS_W;
        state_d = stq_pkg::S_DONE;
      end
      stq_pkg::S_CA_RD: begin
        op_o    = stq_pkg::OP_CA_RD;
        state_d = stq_pkg::S_CA_CK;
      end
      stq_pkg::S_CA_CK: begin
        op_o    = stq_pkg::OP_CA_CK;
        state_d = (stat_i.ca_match && stat_i.scan_st == stq_pkg::ES_RUN)
                  ? stq_pkg::S_UNL_A : stq_pkg::S_CA_NEXT;
      end
      stq_pkg::S_CA_NEXT: begin
        op_o    = stq_pkg::OP_CA_NEXT;
        state_d = stat_i.scan_last ? stq_pkg::S_DONE : stq_pkg::S_CA_RD;
      end
      stq_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          op_o    = stq_pkg::OP_OUT_LOAD;
          load    = 1'b1;
          state_d = stq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = stq_pkg::S_IDLE;
      end
    endcase
  end

  // Output word valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  assign in_stall_o  = (state_q != stq_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == stq_pkg::S_DEC))
    else $error("accepted word did not start decode");
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("result load lost");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

[rtl/stq_dp.sv]
// Datapath for the sorted timer queue: entry state flops, link, deadline and
// queue RAMs, list head, walk pointers and the result register.
// Depends on stq_pkg and stq_ram.
`default_nettype none

module stq_dp #(
  parameter int TIMER_ENTRIES = 16,
  parameter int QUEUE_IDS     = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire stq_pkg::in_word_t  in_word_i,
  input  wire stq_pkg::dp_op_e    op_i,
  output      stq_pkg::dp_stat_t  stat_o,
  output      stq_pkg::out_word_t out_word_o
);

  localparam int IW = $clog2(TIMER_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_ENTRIES - 1);

  stq_pkg::in_word_t  cmd_q, cmd_d;
  stq_pkg::out_word_t out_q, out_d;
  stq_pkg::ent_st_e   st_q [TIMER_ENTRIES];

  logic [IW-1:0] head_q, head_d, e_q, e_d, p_q, p_d, n_q, n_d, le_q, le_d, i_q, i_d;
  logic [31:0]   hdl_q, hdl_d, dl_q, dl_d;
  logic [1:0]    sts_q, sts_d;
  logic [IW-1:0] grant_q, grant_d;
  logic          wasrun_q, wasrun_d;
  logic [3:0]    cnt_q, cnt_d, cnt_inc;

  // Entry state write port
  logic             st_we;
  logic [IW-1:0]    st_wa;
  stq_pkg::ent_st_e st_wd;

  // RAM ports
  logic          lk_we;
  logic [IW-1:0] lk_wa, lk_wd, lk_ra, lk_rd, link_val;
  logic          dm_we;
  logic [IW-1:0] dm_wa, dm_ra;
  logic [31:0]   dm_wd, dm_rd, dl_val;
  logic          mt_we;
  logic [IW-1:0] mt_wa, mt_ra;
  logic [4:0]    mt_wd, mt_rd;
  logic          lz_q, dz_q;

  logic          idx_ok;
  logic [IW-1:0] idx_w, idx_safe;

  // Decode the addressed entry
  assign idx_ok   = (cmd_q.timer_index != 4'd0) && (32'(cmd_q.timer_index) < TIMER_ENTRIES);
  assign idx_w    = IW'(cmd_q.timer_index);
  assign idx_safe = idx_ok ? idx_w : '0;
  assign cnt_inc  = (cnt_q == stq_pkg::CNT_MAX) ? cnt_q : cnt_q + 4'd1;

  // Entry 0 reads as the sentinel: link zero, deadline all ones
  assign link_val = lz_q ? '0 : lk_rd;
  assign dl_val   = dz_q ? stq_pkg::DL_ALL_ONES : dm_rd;

  // Status toward the controller
  always_comb begin
    stat_o.action    = cmd_q.action;
    stat_o.idx_ok    = idx_ok;
    stat_o.qid_ok    = 32'(cmd_q.queue_id) < QUEUE_IDS;
    stat_o.idx_st    = st_q[idx_safe];
    stat_o.scan_st   = st_q[i_q];
    stat_o.scan_last = (i_q == LAST_IDX);
    stat_o.ca_match  = (st_q[i_q] != stq_pkg::ES_FREE) && mt_rd[0] &&
                       (mt_rd[4:1] == cmd_q.queue_id);
    stat_o.head_is_e = (head_q == e_q);
    stat_o.ins_front = (dl_q <= hdl_q);
    stat_o.walk_hit  = (link_val == e_q);
    stat_o.walk_end  = (link_val == '0);
    stat_o.ins_hit   = (dl_q <= dl_val);
  end

  // Carry out the controller's op
  always_comb begin
    cmd_d = cmd_q;     out_d = out_q;
    head_d = head_q;   hdl_d = hdl_q;
    e_d = e_q;   p_d = p_q;   n_d = n_q;   le_d = le_q;   i_d = i_q;   dl_d = dl_q;
    sts_d = sts_q;   grant_d = grant_q;   wasrun_d = wasrun_q;   cnt_d = cnt_q;
    st_we = 1'b0;   st_wa = e_q;   st_wd = stq_pkg::ES_FREE;
    lk_we = 1'b0;   lk_wa = e_q;   lk_wd = head_q;   lk_ra = e_q;
    dm_we = 1'b0;   dm_wa = e_q;   dm_wd = dl_q;     dm_ra = link_val;
    mt_we = 1'b0;   mt_wa = idx_w; mt_wd = {cmd_q.queue_id, cmd_q.auto_cancel};
    mt_ra = i_q;
    case (op_i)
      stq_pkg::OP_LATCH: begin
        cmd_d = in_word_i;
        sts_d = stq_pkg::STS_OK;   grant_d = '0;   wasrun_d = 1'b0;   cnt_d = 4'd0;
      end
      stq_pkg::OP_SET_ERR:  sts_d = stq_pkg::STS_BAD;
      stq_pkg::OP_SET_BUSY: sts_d = stq_pkg::STS_RUNNING;
      stq_pkg::OP_SCAN_START: i_d = IW'(1);
      stq_pkg::OP_ALLOC_STEP: begin
        if (st_q[i_q] == stq_pkg::ES_FREE) begin
          st_we = 1'b1;   st_wa = i_q;   st_wd = stq_pkg::ES_ALLOC;
          mt_we = 1'b1;   mt_wa = i_q;   mt_wd = '0;
          grant_d = i_q;
        end else if (i_q == LAST_IDX) begin
          sts_d = stq_pkg::STS_NO_FREE;
        end else begin
          i_d = i_q + IW'(1);
        end
      end
      stq_pkg::OP_FREE_IDLE: begin
        st_we = 1'b1;   st_wa = idx_w;   st_wd = stq_pkg::ES_FREE;
      end
      stq_pkg::OP_BIND: mt_we = 1'b1;
      stq_pkg::OP_ARM_START: begin
        e_d  = idx_w;
        dl_d = cmd_q.now + cmd_q.delay;
      end
      stq_pkg::OP_CANCEL_START: begin
        e_d      = idx_w;
        wasrun_d = 1'b1;
      end
      stq_pkg::OP_ENT_START: e_d = idx_w;
      // Unlink: fetch successor of e, then fix head or predecessor
      stq_pkg::OP_UNL_A: lk_ra = e_q;
      stq_pkg::OP_UNL_B: begin
        le_d  = link_val;
        dm_ra = link_val;
        p_d   = head_q;
        lk_ra = head_q;
      end
      stq_pkg::OP_UNL_HD: begin
        head_d = le_q;
        hdl_d  = dl_val;
      end
      stq_pkg::OP_UNL_WALK: begin
        if (link_val == e_q) begin
          lk_we = 1'b1;   lk_wa = p_q;   lk_wd = le_q;
        end else begin
          p_d   = link_val;
          lk_ra = link_val;
        end
      end
      stq_pkg::OP_UNL_FIN: begin
        st_we = 1'b1;   st_wa = e_q;
        st_wd = (cmd_q.action == stq_pkg::ACT_CANCEL) ? stq_pkg::ES_ALLOC : stq_pkg::ES_FREE;
        if (cmd_q.action == stq_pkg::ACT_CANCEL_ALL) begin
          cnt_d = cnt_inc;
        end
      end
      // Insert: front of list or walk to first deadline not smaller
      stq_pkg::OP_INS_A: begin
        dm_we = 1'b1;   dm_wa = e_q;   dm_wd = dl_q;
        st_we = 1'b1;   st_wa = e_q;   st_wd = stq_pkg::ES_RUN;
        if (dl_q <= hdl_q) begin
          lk_we  = 1'b1;   lk_wa = e_q;   lk_wd = head_q;
          head_d = e_q;
          hdl_d  = dl_q;
        end else begin
          p_d   = head_q;
          lk_ra = head_q;
        end
      end
      stq_pkg::OP_INS_N: begin
        n_d   = link_val;
        dm_ra = link_val;
      end
      stq_pkg::OP_INS_C: begin
        if (dl_q <= dl_val) begin
          lk_we = 1'b1;   lk_wa = p_q;   lk_wd = e_q;
        end else begin
          p_d   = n_q;
          lk_ra = n_q;
        end
      end
      stq_pkg::OP_INS_W: begin
        lk_we = 1'b1;   lk_wa = e_q;   lk_wd = n_q;
      end
      // Cancel-all scan
      stq_pkg::OP_CA_RD: mt_ra = i_q;
      stq_pkg::OP_CA_CK: begin
        if (stat_o.ca_match) begin
          if (st_q[i_q] == stq_pkg::ES_RUN) begin
            e_d = i_q;
          end else begin
            st_we = 1'b1;   st_wa = i_q;   st_wd = stq_pkg::ES_FREE;
            cnt_d = cnt_inc;
          end
        end
      end
      stq_pkg::OP_CA_NEXT: begin
        if (i_q != LAST_IDX) begin
          i_d = i_q + IW'(1);
        end
      end
      stq_pkg::OP_OUT_LOAD: begin
        out_d.status          = sts_q;
        out_d.allocated_index = 4'(16'(grant_q));
        out_d.was_running     = wasrun_q;
        out_d.cancelled_count = cnt_q;
        out_d.head_index      = 4'(16'(head_q));
        out_d.next_deadline   = hdl_q;
      end
      default: begin
      end
    endcase
  end

  // Control state: list head and entry states
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      hdl_q  <= stq_pkg::DL_ALL_ONES;
      for (int j = 0; j < TIMER_ENTRIES; j++) begin
        st_q[j] <= (j == 0) ? stq_pkg::ES_RUN : stq_pkg::ES_FREE;
      end
    end else begin
      head_q <= head_d;
      hdl_q  <= hdl_d;
      for (int j = 0; j < TIMER_ENTRIES; j++) begin
        if (st_we && (st_wa == IW'(j))) begin
          st_q[j] <= st_wd;
        end
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;   out_q <= out_d;
    e_q <= e_d;   p_q <= p_d;   n_q <= n_d;   le_q <= le_d;   i_q <= i_d;   dl_q <= dl_d;
    sts_q <= sts_d;   grant_q <= grant_d;   wasrun_q <= wasrun_d;   cnt_q <= cnt_d;
    lz_q <= (lk_ra == '0);
    dz_q <= (dm_ra == '0);
  end

  stq_ram #(.WIDTH(IW), .DEPTH(TIMER_ENTRIES)) u_link_ram (
    .clk_i, .we_i(lk_we), .waddr_i(lk_wa), .wdata_i(lk_wd), .raddr_i(lk_ra), .rdata_o(lk_rd)
  );

  stq_ram #(.WIDTH(32), .DEPTH(TIMER_ENTRIES)) u_dl_ram (
    .clk_i, .we_i(dm_we), .waddr_i(dm_wa), .wdata_i(dm_wd), .raddr_i(dm_ra), .rdata_o(dm_rd)
  );

  stq_ram #(.WIDTH(5), .DEPTH(TIMER_ENTRIES)) u_queue_ram (
    .clk_i, .we_i(mt_we), .waddr_i(mt_wa), .wdata_i(mt_wd), .raddr_i(mt_ra), .rdata_o(mt_rd)
  );

  assign out_word_o = out_q;

`ifndef NO_ASSERTIONS
  a_sentinel_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == '0) |-> (hdl_q == stq_pkg::DL_ALL_ONES))
    else $error("sentinel at head with wrong deadline");
  a_sentinel_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q[0] == stq_pkg::ES_RUN)
    else $error("sentinel entry left running state");
  a_latch_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == stq_pkg::OP_LATCH) |=> (cnt_q == 4'd0 && !wasrun_q))
    else $error("result fields not cleared on new word");
`endif

endmodule

`default_nettype wire

[rtl/sorted_timer_queue.sv]
// Bind and error words need no walk; allocate scans entries from index 1 for a
// free one, arm walks the list to its insertion point, cancel/free of a running
// entry walk the list to unlink it (link RAM read each step), cancel-all scans
// entries from index 1 and unlinks each running match. One word at a time.
// The result register frees the input side as soon as the result is loaded.
// Reset (async, active low) leaves only the sentinel running, head = entry 0.
// Top level of the sorted timer queue; depends on stq_pkg, stq_ctrl, stq_dp.
`default_nettype none

module sorted_timer_queue #(
  parameter int TIMER_ENTRIES = 16,
  parameter int QUEUE_IDS     = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire stq_pkg::in_word_t  in_word_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      stq_pkg::out_word_t out_word_o
);

  stq_pkg::dp_op_e   op;
  stq_pkg::dp_stat_t stat;

  stq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .op_o(op)
  );

  stq_dp #(.TIMER_ENTRIES(TIMER_ENTRIES), .QUEUE_IDS(QUEUE_IDS)) u_dp (
    .clk_i, .rst_ni, .in_word_i, .op_i(op), .stat_o(stat), .out_word_o
  );

endmodule

`default_nettype wire
